/* rtl/evqt_pkg.sv */
package evqt_pkg;

  // Default for the full-scale position in ticks
  localparam int unsigned TOTAL_TICKS_DEF = 200;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned POS_OUT_W = 8;
  localparam int unsigned Q16_W     = 17;
  // Quotient bits produced by the shared divider
  localparam int unsigned QUO_W     = 17;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd2;

  localparam logic [THR_W-1:0]   THR_RST   = 8'd14;
  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd500;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ZERO   = 1'b1;

  localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic             opcode;
    logic [CNT_W-1:0] encoder_count;
    logic [MS_W-1:0]  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] position_ticks;
    logic [Q16_W-1:0]     percentage_q16;
    logic [Q16_W-1:0]     volume_q16;
    logic [Q16_W-1:0]     unlock_progress_q16;
    logic                 quick_turned;
  } out_item_t;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/evqt_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle; stops once b runs out of ones.
module evqt_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W = A_W + B_W;

  logic           busy_q;
  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic [P_W-1:0] p_q;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= P_W'(a_i);
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

/* rtl/evqt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor * 2**QUO_W.
module evqt_div
  import evqt_pkg::*;
#(
  parameter int unsigned DV_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DV_W+QUO_W-1:0] dividend_i,
  input  logic [DV_W-1:0]       divisor_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  localparam int unsigned CW = $clog2(QUO_W + 1);
  localparam logic [CW-1:0] LAST = CW'(QUO_W);

  logic            busy_q;
  logic [CW-1:0]   cnt_q;
  logic [DV_W-1:0] rem_q;
  logic [DV_W-1:0] dvs_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;

  logic [DV_W:0] trial;
  logic [DV_W:0] diff;
  logic          fits;

  assign trial  = {rem_q, low_q[QUO_W-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign fits   = (trial >= {1'b0, dvs_q});
  assign done_o = busy_q && (cnt_q == LAST);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DV_W+QUO_W-1:QUO_W];
      low_q <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q && !done_o) begin
      rem_q <= fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

endmodule

/* rtl/encoder_volume_quick_turn_tracker.sv */
// Arithmetic: one shift-add multiplier (one bit per cycle) and one restoring
//   divider (17 quotient steps), reused in sequence.
// Throughput: one item at a time; the next item is taken once the result sits in
//   the output register, so the sink only stalls the block while that register is full.
// Reset: asynchronous, active low; clears position, previous count and accumulator.
//   Registers return to unlocked, threshold 14, decay time 500 ms.
module encoder_volume_quick_turn_tracker
  import evqt_pkg::*;
#(
  parameter int unsigned TOTAL_TICKS = TOTAL_TICKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Widths that follow from the full-scale position
  // ---------------------------------------------------------------------------
  localparam int unsigned PW   = $clog2(TOTAL_TICKS + 1);
  localparam int unsigned MA_W = max_u(ACC_W, 2 * PW + 2);   // multiplicand
  localparam int unsigned MB_W = max_u(DECAY_W, PW);         // serial multiplier
  localparam int unsigned MP_W = MA_W + MB_W;
  localparam int unsigned DV_W = max_u(DECAY_W, 3 * PW);     // widest divisor is T^3
  localparam int unsigned N_W  = DV_W + QUO_W;
  localparam int unsigned SW   = max_u(PW, CNT_W) + 2;       // signed position sum

  localparam longint unsigned TT      = TOTAL_TICKS;
  localparam longint unsigned T3      = TT * TT * TT;
  localparam longint unsigned FOUR_T2 = 4 * TT * TT;
  localparam longint unsigned THREE_T = 3 * TT;
  localparam longint unsigned HALF_T  = TT / 2;
  localparam longint unsigned HALF_T3 = T3 / 2;

  localparam logic signed [SW-1:0] T_S   = SW'(TOTAL_TICKS);
  localparam logic [PW-1:0]        T_POS = PW'(TOTAL_TICKS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC_MUL,
    ST_DEC_DIV,
    ST_ADD,
    ST_PCT,
    ST_PROG,
    ST_SQ,
    ST_P3T,
    ST_NUM,
    ST_VOL,
    ST_OUT
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e state_q;

  logic               lock_q;
  logic [THR_W-1:0]   thr_q;
  logic [DECAY_W-1:0] dec_q;

  logic [CNT_W-1:0] prev_q;
  logic [PW-1:0]    pos_q;
  logic [ACC_W-1:0] acc_q;

  // per-item scratch
  logic             neg_q;
  logic [CNT_W-1:0] mag_q;
  logic [2*PW-1:0]  sq_q;
  logic [Q16_W-1:0] pct_q;
  logic [Q16_W-1:0] prog_q;
  logic             qt_q;
  logic [Q16_W-1:0] vol_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  // unit requests, registered in the sequencer
  logic            mul_start_q;
  logic            mul_start_d;
  logic [MA_W-1:0] mul_a_q;
  logic [MB_W-1:0] mul_b_q;
  logic            div_start_q;
  logic            div_start_d;
  logic [N_W-1:0]  div_n_q;
  logic [DV_W-1:0] div_d_q;

  logic             mul_done;
  logic [MP_W-1:0]  mul_p;
  logic             div_done;
  logic [QUO_W-1:0] div_q;

  // ---------------------------------------------------------------------------
  // Shared arithmetic units
  // ---------------------------------------------------------------------------
  evqt_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  evqt_div #(
    .DV_W (DV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .done_o     (div_done),
    .quo_o      (div_q)
  );

  // ---------------------------------------------------------------------------
  // Sample front end: wrapped delta and clamped position
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]        diff;
  logic signed [SW-1:0]    psum;
  logic [PW-1:0]           pos_clamped;
  logic                    in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;
  assign diff    = in_data_i.encoder_count - prev_q;
  assign psum    = $signed(SW'(pos_q)) + SW'($signed(diff));

  always_comb begin
    if (psum < 0) begin
      pos_clamped = '0;
    end else if (psum > T_S) begin
      pos_clamped = T_POS;
    end else begin
      pos_clamped = psum[PW-1:0];
    end
  end

  // backward motion added in Q8.8, saturating
  logic [ACC_W+CNT_W-7:0] acc_sum;
  logic [ACC_W-1:0]       acc_added;

  assign acc_sum   = (ACC_W + CNT_W - 6)'(acc_q) + (ACC_W + CNT_W - 6)'({mag_q, 8'h00});
  assign acc_added = (acc_sum[ACC_W+CNT_W-7:ACC_W] != '0) ? '1 : acc_sum[ACC_W-1:0];

  // p^2 - 3pT + 4T^2 from the square and the product by 3T
  logic [MP_W-1:0] inner_full;
  assign inner_full = MP_W'(sq_q) + MP_W'(FOUR_T2) - mul_p;

  logic qt_now;
  assign qt_now = (acc_q >= {thr_q, 8'h00});   // also covers a zero threshold

  // ---------------------------------------------------------------------------
  // Configuration: always ready, taken only while idle by contract
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b0;
      thr_q  <= THR_RST;
      dec_q  <= DECAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOCK:   lock_q <= cfg_data_i[0];
        CFG_THRESH: thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_DECAY:  dec_q  <= cfg_data_i[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Unit start pulses, one cycle each
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    unique case (state_q)
      ST_IDLE:    mul_start_d = in_xfer && (in_data_i.opcode == OP_SAMPLE) &&
                                (in_data_i.elapsed_ms < dec_q);
      ST_DEC_MUL: div_start_d = mul_done;
      ST_ADD:     div_start_d = 1'b1;
      ST_PCT: begin
        mul_start_d = div_done && qt_now;
        div_start_d = div_done && !qt_now;
      end
      ST_PROG:    mul_start_d = div_done;
      ST_SQ:      mul_start_d = mul_done;
      ST_P3T:     mul_start_d = mul_done;
      ST_NUM:     div_start_d = mul_done;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      // a reload in ST_OUT takes the place of the clear
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data_i.opcode == OP_ZERO) begin
              // position only; count and accumulator untouched
              neg_q   <= 1'b0;
              pos_q   <= '0;
              state_q <= ST_ADD;
            end else begin
              prev_q <= in_data_i.encoder_count;
              if (!lock_q) begin
                pos_q <= pos_clamped;
              end
              neg_q <= diff[CNT_W-1];
              mag_q <= (~diff) + 1'b1;
              if (in_data_i.elapsed_ms >= dec_q) begin
                acc_q   <= '0;
                state_q <= ST_ADD;
              end else begin
                // acc * (decay - dt) / decay
                mul_a_q     <= MA_W'(acc_q);
                mul_b_q     <= MB_W'(dec_q - in_data_i.elapsed_ms);
                state_q     <= ST_DEC_MUL;
              end
            end
          end
        end

        ST_DEC_MUL: begin
          if (mul_done) begin
            div_n_q     <= N_W'(mul_p);
            div_d_q     <= DV_W'(dec_q);
            state_q     <= ST_DEC_DIV;
          end
        end

        ST_DEC_DIV: begin
          if (div_done) begin
            acc_q   <= div_q[ACC_W-1:0];
            state_q <= ST_ADD;
          end
        end

        ST_ADD: begin
          if (neg_q) begin
            acc_q <= acc_added;
          end
          // percentage: round(p * 65536 / T)
          div_n_q     <= N_W'({pos_q, 16'h0000}) + N_W'(HALF_T);
          div_d_q     <= DV_W'(TT);
          state_q     <= ST_PCT;
        end

        ST_PCT: begin
          if (div_done) begin
            pct_q <= div_q;
            qt_q  <= qt_now;
            if (qt_now) begin
              // quotient would reach one or more: clamp, skip the divide
              prog_q      <= Q16_ONE;
              mul_a_q     <= MA_W'(pos_q);
              mul_b_q     <= MB_W'(pos_q);
              state_q     <= ST_SQ;
            end else begin
              div_n_q     <= N_W'({acc_q, 8'h00}) + N_W'(thr_q >> 1);
              div_d_q     <= DV_W'(thr_q);
              state_q     <= ST_PROG;
            end
          end
        end

        ST_PROG: begin
          if (div_done) begin
            prog_q      <= div_q;
            mul_a_q     <= MA_W'(pos_q);
            mul_b_q     <= MB_W'(pos_q);
            state_q     <= ST_SQ;
          end
        end

        ST_SQ: begin
          if (mul_done) begin
            sq_q        <= mul_p[2*PW-1:0];
            mul_a_q     <= MA_W'(THREE_T);
            mul_b_q     <= MB_W'(pos_q);
            state_q     <= ST_P3T;
          end
        end

        ST_P3T: begin
          if (mul_done) begin
            mul_a_q     <= inner_full[MA_W-1:0];
            mul_b_q     <= MB_W'(pos_q);
            state_q     <= ST_NUM;
          end
        end

        ST_NUM: begin
          if (mul_done) begin
            // volume: round(32768 * num / T^3)
            div_n_q     <= (N_W'(mul_p) << 15) + N_W'(HALF_T3);
            div_d_q     <= DV_W'(T3);
            state_q     <= ST_VOL;
          end
        end

        ST_VOL: begin
          if (div_done) begin
            vol_q   <= (div_q > Q16_ONE) ? Q16_ONE : div_q;
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q                    <= 1'b1;
            out_data_q.position_ticks      <= POS_OUT_W'(pos_q);
            out_data_q.percentage_q16      <= pct_q;
            out_data_q.volume_q16          <= vol_q;
            out_data_q.unlock_progress_q16 <= prog_q;
            out_data_q.quick_turned        <= qt_q;
            state_q                        <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= T_POS)
    else $error("position beyond full scale");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken again before the result was built");

  a_qt_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.quick_turned) |->
      (out_data_q.unlock_progress_q16 == Q16_ONE))
    else $error("quick turn flagged without full unlock progress");

  a_q16_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q.percentage_q16 <= Q16_ONE) &&
                     (out_data_q.volume_q16 <= Q16_ONE)))
    else $error("Q0.16 result above one");

endmodule

/* sim/encoder_volume_quick_turn_tracker_tb.sv */
`timescale 1ns / 100ps

module encoder_volume_quick_turn_tracker_tb
  import evqt_pkg::*;
;

  localparam int unsigned TICKS      = TOTAL_TICKS_DEF;
  // Covers the worst item, plus the longest sender gap and sink stall.
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned END_WAIT   = 150;
  localparam int unsigned SHOW_MAX   = 10;
  // Index 3 is not decoded: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Predicts every result from its own copy of the registers and the
  // tracker state, and holds the predictions in arrival order.
  class volume_tracker_ledger;
    bit                 lock_on;
    logic [THR_W-1:0]   thresh;
    logic [DECAY_W-1:0] decay_ms;
    logic [CNT_W-1:0]   last_count;
    int unsigned        pos;
    logic [ACC_W-1:0]   back_acc;
    out_item_t          pending[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function void clear();
      lock_on    = 1'b0;
      thresh     = THR_RST;
      decay_ms   = DECAY_RST;
      last_count = '0;
      pos        = 0;
      back_acc   = '0;
      pending.delete();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOCK:   lock_on  = val[0];
        CFG_THRESH: thresh   = val[THR_W-1:0];
        CFG_DECAY:  decay_ms = val[DECAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      logic [CNT_W-1:0]  diff;
      int                delta;
      int                p_next;
      longint unsigned   acc, p, t3, num, vol, pct, prog, dec, el;
      out_item_t         want;
      if (it.opcode == OP_ZERO) begin
        // position only; count history and accumulator stay
        pos = 0;
      end else begin
        diff       = it.encoder_count - last_count;
        delta      = int'($signed(diff));
        last_count = it.encoder_count;
        if (!lock_on) begin
          p_next = int'(pos) + delta;
          if (p_next < 0) p_next = 0;
          if (p_next > int'(TICKS)) p_next = TICKS;
          pos = p_next;
        end
        dec = decay_ms;
        el  = it.elapsed_ms;
        // linear leak first (zero decay time always clears), then add backward motion
        if (el >= dec) acc = 0;
        else acc = (longint'(back_acc) * (dec - el)) / dec;
        if (delta < 0) begin
          acc = acc + longint'(-delta) * 256;
          if (acc > 64'hFFFF) acc = 64'hFFFF;
        end
        back_acc = acc[ACC_W-1:0];
      end

      p   = pos;
      pct = (p * 65536 + TICKS / 2) / TICKS;
      t3  = longint'(TICKS) * TICKS * TICKS;
      num = p * p * p + 4 * p * TICKS * TICKS - 3 * p * p * TICKS;
      vol = (num * 32768 + t3 / 2) / t3;
      if (vol > 65536) vol = 65536;

      want.position_ticks = p[POS_OUT_W-1:0];
      want.percentage_q16 = pct[Q16_W-1:0];
      want.volume_q16     = vol[Q16_W-1:0];
      if (thresh == 0) begin
        want.unlock_progress_q16 = Q16_ONE;
        want.quick_turned        = 1'b1;
      end else begin
        prog = (longint'(back_acc) * 256 + thresh / 2) / thresh;
        if (prog > 65536) prog = 65536;
        want.unlock_progress_q16 = prog[Q16_W-1:0];
        want.quick_turned        = (longint'(back_acc) >= longint'(thresh) * 256);
      end
      pending.push_back(want);
    endfunction

    function string show(out_item_t r);
      return $sformatf("pos=%0d pct=%0d vol=%0d prog=%0d qt=%0d", r.position_ticks,
                       r.percentage_q16, r.volume_q16, r.unlock_progress_q16,
                       r.quick_turned);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      bit        bad;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("[%0t] unexpected result: %s", $realtime, show(got));
      end else begin
        want = pending.pop_front();
        bad  = (got.position_ticks      !== want.position_ticks)      ||
               (got.percentage_q16      !== want.percentage_q16)      ||
               (got.volume_q16          !== want.volume_q16)          ||
               (got.unlock_progress_q16 !== want.unlock_progress_q16) ||
               (got.quick_turned        !== want.quick_turned);
        if (bad) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("[%0t] result %0d mismatch", $realtime, checked);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  volume_tracker_ledger ledger;

  // no-gap mode for both sides during one random phase
  bit               steady;
  // the encoder count the stimulus believes the knob is at
  logic [CNT_W-1:0] count_cursor;
  int unsigned      n_items;
  int unsigned      n_zero;
  int unsigned      n_settings;

  encoder_volume_quick_turn_tracker #(
    .TOTAL_TICKS(TICKS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // All tasks below start and end at a falling edge. Valid stays high
  // across back-to-back transfers and is only lowered ahead of a gap or by drain().
  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.take_item(it);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic put_sample(logic [CNT_W-1:0] cnt, logic [MS_W-1:0] dt);
    in_item_t it;
    it.opcode        = OP_SAMPLE;
    it.encoder_count = cnt;
    it.elapsed_ms    = dt;
    count_cursor     = cnt;
    send_item(it, pick_gap());
  endtask

  // count and elapsed time are don't-cares here, so fill them with junk
  task automatic put_zero();
    in_item_t it;
    it.opcode        = OP_ZERO;
    it.encoder_count = CNT_W'($urandom);
    it.elapsed_ms    = MS_W'($urandom);
    n_zero++;
    send_item(it, pick_gap());
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_regs(bit lk, logic [THR_W-1:0] thr, logic [DECAY_W-1:0] dec);
    write_reg(CFG_LOCK, CFG_DATA_W'(lk));
    write_reg(CFG_THRESH, CFG_DATA_W'(thr));
    write_reg(CFG_DECAY, dec);
    n_settings++;
  endtask

  // Mostly knob-like motion: small steps, fast backward flicks with short
  // elapsed times so the accumulator builds up; some noise and resets.
  task automatic run_phase(int n);
    int              r;
    int              step;
    logic [MS_W-1:0] dt;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        put_zero();
      end else if (r < 15) begin
        put_sample(CNT_W'($urandom), MS_W'($urandom));
      end else begin
        if (r < 35) step = -int'($urandom_range(2, 12));
        else if (r < 40) step = int'($urandom_range(0, 65535)) - 32768;
        else step = int'($urandom_range(0, 40)) - 20;
        r = $urandom_range(0, 99);
        if (r < 70) dt = MS_W'($urandom_range(0, 30));
        else if (r < 92) dt = MS_W'($urandom_range(0, 1500));
        else dt = MS_W'($urandom);
        put_sample(count_cursor + CNT_W'(step), dt);
      end
    end
  endtask

  // Result sink: random stalls, checked at the rising edge.
  initial begin : result_sink
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.match_result(out_data_o);
  end

  // Ends the run if no channel moves a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, ledger.pending.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned fails;
    ledger = new();
    ledger.clear();
    steady       = 1'b0;
    count_cursor = '0;
    n_items      = 0;
    n_zero       = 0;
    n_settings   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed, register values from reset ----
    put_sample(16'd0, 16'd0);          // no motion at all
    put_sample(16'd50, 16'd10);
    put_sample(16'd32817, 16'd5);      // largest forward step, clamps at full scale
    put_sample(16'd49, 16'd0);         // largest backward step, accumulator saturates
    put_sample(16'd49, 16'd0);         // no elapsed time: no decay
    put_sample(16'd49, 16'd499);       // one ms short of full decay
    put_sample(16'd39, 16'd500);       // full decay, then a 10-tick backward step
    put_sample(16'hFFFF, 16'd3);       // backward across the count wrap
    put_sample(16'h0000, 16'd3);       // forward across the count wrap
    put_zero();
    put_sample(16'd200, 16'hFFFF);     // exactly full scale from zero, longest elapsed
    put_sample(16'd201, 16'd1);        // one past full scale
    drain();

    // locked: motion ignored, accumulator still runs, zeroing still works
    program_regs(1'b1, THR_RST, DECAY_RST);
    put_sample(16'd150, 16'd20);
    put_sample(16'd100, 16'd2);
    put_zero();
    put_sample(16'd300, 16'd1);
    drain();

    // zero threshold and zero decay time
    program_regs(1'b0, 8'd0, 16'd0);
    put_sample(16'd290, 16'd0);
    put_sample(16'd310, 16'd0);
    drain();

    // widest threshold and decay time
    program_regs(1'b0, 8'd255, 16'hFFFF);
    put_sample(16'd54, 16'd0);         // 256 ticks back: saturates
    put_sample(16'd54, 16'd65534);     // leaks down to almost nothing
    drain();

    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    program_regs(1'b0, 8'd1, 16'd1);
    put_sample(16'd50, 16'd0);
    put_sample(16'd50, 16'd1);
    drain();

    // ---- random phases over several register settings ----
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(1'b0, THR_RST, DECAY_RST);
        1: program_regs(1'b0, THR_W'($urandom_range(1, 255)), DECAY_W'($urandom_range(1, 2000)));
        2: program_regs(1'b1, THR_RST, DECAY_RST);
        3: program_regs(1'b0, 8'd255, 16'hFFFF);
        4: program_regs(1'b0, 8'd1, 16'd1);
        5: program_regs(1'b0, 8'd0, 16'd0);
        6: program_regs(1'b1, THR_W'($urandom), DECAY_W'($urandom));
        default: program_regs(1'b0, THR_W'($urandom_range(1, 255)),
                              DECAY_W'($urandom_range(1, 65535)));
      endcase
      steady = (ph == 3);
      run_phase(100);
      drain();
    end
    steady = 1'b0;

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    fails = ledger.mismatches + ledger.pending.size();
    $display("covered %0d items (%0d position zeroings) over %0d register settings",
             n_items, n_zero, n_settings);
    $display("%0d results checked, %0d mismatches", ledger.checked, fails);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
